// ===== rtl/mbc_pkg.sv =====
// Package for the multi-LED blink controller.
// Holds the request op codes, the fixed field widths and the per-LED command struct.
// No dependencies.
package mbc_pkg;

   localparam int OP_BITS   = 2;
   localparam int IDX_BITS  = 3;
   localparam int TICK_BITS = 16;
   localparam int PORT_BITS = 8;

   localparam logic [OP_BITS-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ANIMATE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SET     = 2'd2;
   localparam logic [OP_BITS-1:0] OP_TOGGLE  = 2'd3;

   // Command broadcast from the decoder to one LED lane.
   typedef struct packed {
      logic tick;
      logic animate;
      logic set;
      logic toggle;
      logic level;
   } lane_cmd_type;

endpackage

// ===== rtl/mbc_led.sv =====
// One LED lane: level flag, down counter and on/off durations.
// Depends on mbc_pkg for the lane command struct.
module mbc_led #(
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mbc_pkg::lane_cmd_type   cmd,
   input  logic [COUNT_BITS-1:0]   on_ticks,
   input  logic [COUNT_BITS-1:0]   off_ticks,
   output logic                    lit_next
);
   import mbc_pkg::*;

   logic                  lit_ff, lit_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] on_ff, on_in;
   logic [COUNT_BITS-1:0] off_ff, off_in;
   logic [COUNT_BITS-1:0] cnt_dec;

   assign cnt_dec = cnt_ff - COUNT_BITS'(1);

   always_comb begin
      lit_in = lit_ff;
      cnt_in = cnt_ff;
      on_in  = on_ff;
      off_in = off_ff;
      if (cmd.tick) begin
         if (cnt_ff != '0) begin
            if (cnt_dec == '0) begin
               // expire: flip level and reload for the new level
               lit_in = ~lit_ff;
               cnt_in = lit_ff ? off_ff : on_ff;
            end else begin
               cnt_in = cnt_dec;
            end
         end
      end else if (cmd.animate) begin
         lit_in = 1'b1;
         on_in  = on_ticks;
         off_in = off_ticks;
         cnt_in = on_ticks;
      end else if (cmd.set) begin
         lit_in = cmd.level;
         cnt_in = '0;
      end else if (cmd.toggle) begin
         lit_in = ~lit_ff;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff <= 1'b0;
         cnt_ff <= '0;
         on_ff  <= '0;
         off_ff <= '0;
      end else begin
         lit_ff <= lit_in;
         cnt_ff <= cnt_in;
         on_ff  <= on_in;
         off_ff <= off_in;
      end
   end

   assign lit_next = lit_in;

endmodule

// ===== rtl/multi_led_blink_controller.sv =====
// Top level of the multi-LED blink controller: request decode, LED lanes, port register.
// Depends on mbc_pkg and mbc_led.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | op, led_index, set_level, on/off ticks
//   rsp     | out       | rsp_valid/rsp_stall  | port_pattern (tick requests only)
//
// One request is taken per cycle while req_stall is low. Each lane a request reaches
// updates as it is taken, and a tick's port byte enters the result register at that edge.
// Reset (synchronous, active high) clears all levels, counters and durations.
// A pending result that is stalled blocks the request side; when it is taken in the
// same cycle, the next request still goes through, so full rate holds without stalls.
module multi_led_blink_controller #(
   parameter int NUM_LEDS   = 7,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mbc_pkg::OP_BITS-1:0]       req_op,
   input  logic [mbc_pkg::IDX_BITS-1:0]      req_led_index,
   input  logic                              req_set_level,
   input  logic [mbc_pkg::TICK_BITS-1:0]     req_on_ticks,
   input  logic [mbc_pkg::TICK_BITS-1:0]     req_off_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mbc_pkg::PORT_BITS-1:0]     rsp_port_pattern
);
   import mbc_pkg::*;

   logic                  req_take;
   logic                  is_tick;
   logic [COUNT_BITS-1:0] on_cnt;
   logic [COUNT_BITS-1:0] off_cnt;
   logic [NUM_LEDS-1:0]   lit_next;
   logic [PORT_BITS-1:0]  pattern;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PORT_BITS-1:0]  pattern_ff, pattern_in;

   // hold requests while an untaken result sits in the output register
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign is_tick   = (req_op == OP_TICK);

   // fit the 16-bit durations to the counter width: truncate or zero-extend
   for (genvar b = 0; b < COUNT_BITS; b++) begin : g_fit
      if (b < TICK_BITS) begin : g_bit
         assign on_cnt[b]  = req_on_ticks[b];
         assign off_cnt[b] = req_off_ticks[b];
      end else begin : g_zero
         assign on_cnt[b]  = 1'b0;
         assign off_cnt[b] = 1'b0;
      end
   end

   for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
      lane_cmd_type cmd;
      logic         hit;

      // addressed ops only reach the lane whose index matches
      assign hit         = req_take && (req_led_index == IDX_BITS'(i));
      assign cmd.tick    = req_take && is_tick;
      assign cmd.animate = hit && (req_op == OP_ANIMATE);
      assign cmd.set     = hit && (req_op == OP_SET);
      assign cmd.toggle  = hit && (req_op == OP_TOGGLE);
      assign cmd.level   = req_set_level;

      mbc_led #(
         .COUNT_BITS (COUNT_BITS)
      ) u_led (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .on_ticks  (on_cnt),
         .off_ticks (off_cnt),
         .lit_next  (lit_next[i])
      );
   end

   // LED0 drives bit 0, LED1..LED6 drive bits 7 down to 2; buzzer bit stays low
   always_comb begin
      pattern = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         if (i == 0) begin
            pattern[0] = lit_next[0];
         end else begin
            pattern[8-i] = lit_next[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pattern_in   = pattern_ff;
      if (req_take && is_tick) begin
         rsp_valid_in = 1'b1;
         pattern_in   = pattern;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_port_pattern = pattern_ff;

endmodule

// ===== tb/tb_multi_led_blink_controller.sv =====
// Self-checking testbench for multi_led_blink_controller: directed and random requests.
// A scoreboard class tracks the seven LED lanes and checks every port byte in order.
// Depends on mbc_pkg and the multi_led_blink_controller RTL.
`timescale 1ns / 100ps

module tb_multi_led_blink_controller;
   import mbc_pkg::*;

   localparam int LED_COUNT    = 7;
   localparam int REAL_ITEMS   = 1200;
   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int MAX_REPORTS  = 10;

   // Track the LED lanes and hold the port bytes that ticks will produce.
   class port_pattern_tracker;
      bit                   lit [LED_COUNT];
      logic [TICK_BITS-1:0] countdown [LED_COUNT];
      logic [TICK_BITS-1:0] on_duration [LED_COUNT];
      logic [TICK_BITS-1:0] off_duration [LED_COUNT];
      logic [PORT_BITS-1:0] expected_patterns [$];
      int                   failures;

      function new();
         for (int i = 0; i < LED_COUNT; i++) begin
            lit[i]          = 1'b0;
            countdown[i]    = '0;
            on_duration[i]  = '0;
            off_duration[i] = '0;
         end
         failures = 0;
      endfunction

      function void note_request(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] idx,
                                 logic lvl, logic [TICK_BITS-1:0] on_t,
                                 logic [TICK_BITS-1:0] off_t);
         logic [PORT_BITS-1:0] pattern;
         if (op == OP_TICK) begin
            for (int i = 0; i < LED_COUNT; i++) begin
               if (countdown[i] != 0) begin
                  countdown[i] = countdown[i] - 1'b1;
                  if (countdown[i] == 0) begin
                     lit[i]       = ~lit[i];
                     countdown[i] = lit[i] ? on_duration[i] : off_duration[i];
                  end
               end
            end
            pattern = '0;
            for (int i = 0; i < LED_COUNT; i++)
               if (lit[i]) pattern[(i == 0) ? 0 : 8 - i] = 1'b1;
            expected_patterns.push_back(pattern);
         end else if (idx < LED_COUNT) begin
            case (op)
               OP_ANIMATE: begin
                  lit[idx]          = 1'b1;
                  on_duration[idx]  = on_t;
                  off_duration[idx] = off_t;
                  countdown[idx]    = on_t;
               end
               OP_SET: begin
                  lit[idx]       = lvl;
                  countdown[idx] = '0;
               end
               default: begin
                  lit[idx]       = ~lit[idx];
                  countdown[idx] = '0;
               end
            endcase
         end
      endfunction

      function void check_pattern(logic [PORT_BITS-1:0] actual);
         logic [PORT_BITS-1:0] expected;
         if (expected_patterns.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("port byte %h arrived with no tick pending", actual);
         end else begin
            expected = expected_patterns.pop_front();
            if (actual !== expected) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("port byte mismatch: expected %h, actual %h", expected, actual);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_BITS-1:0]   req_op;
   logic [IDX_BITS-1:0]  req_led_index;
   logic                 req_set_level;
   logic [TICK_BITS-1:0] req_on_ticks;
   logic [TICK_BITS-1:0] req_off_ticks;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PORT_BITS-1:0] rsp_port_pattern;

   port_pattern_tracker tracker = new();

   // Calm-stretch counters: while nonzero, the side runs without gaps.
   int req_calm_left = 0;
   int rsp_calm_left = 0;

   multi_led_blink_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_led_index    (req_led_index),
      .req_set_level    (req_set_level),
      .req_on_ticks     (req_on_ticks),
      .req_off_ticks    (req_off_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_port_pattern (rsp_port_pattern)
   );

   // 12 ns clock period.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Pick an idle length: mostly none or short, now and then long. Inside a calm
   // stretch return zero so full-rate runs also get exercised.
   function automatic int next_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(30, 80);
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Durations: mostly short so LEDs actually blink, sometimes zero, sometimes wide.
   function automatic logic [TICK_BITS-1:0] pick_duration();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return '0;
      if (roll < 60) return TICK_BITS'($urandom_range(1, 4));
      if (roll < 85) return TICK_BITS'($urandom_range(5, 20));
      if (roll < 95) return TICK_BITS'($urandom);
      return '1;
   endfunction

   // Present one request, optionally after an idle gap, and hold it until taken.
   // Return at the edge where it was accepted.
   task automatic send_request(input logic [OP_BITS-1:0] op, input logic [IDX_BITS-1:0] idx,
                               input logic lvl, input logic [TICK_BITS-1:0] on_t,
                               input logic [TICK_BITS-1:0] off_t);
      int gap;
      gap = next_gap(req_calm_left);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_led_index <= idx;
      req_set_level <= lvl;
      req_on_ticks  <= on_t;
      req_off_ticks <= off_t;
      do @(posedge clock); while (req_stall);
   endtask

   // Receiver side: drive rsp_stall with random bursts and calm stretches.
   initial begin : rsp_stall_driver
      int n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         n = next_gap(rsp_calm_left);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   end

   // Watch both handshakes at the edge. Predict on every accepted request and
   // compare every accepted port byte against the oldest pending one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_pattern(rsp_port_pattern);
         if (req_valid && !req_stall)
            tracker.note_request(req_op, req_led_index, req_set_level,
                                 req_on_ticks, req_off_ticks);
      end
   end

   // Main sequence: reset, directed requests, random requests, drain, verdict.
   initial begin : stimulus
      int                   sent;
      int                   waited;
      int                   roll;
      logic [OP_BITS-1:0]   op;
      logic [IDX_BITS-1:0]  idx;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_op        <= OP_TICK;
      req_led_index <= '0;
      req_set_level <= 1'b0;
      req_on_ticks  <= '0;
      req_off_ticks <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tick from reset, animate every LED (one with zero on time,
      // one with zero off time so it goes dark and stays dark), then ticks.
      send_request(OP_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000);
      for (int i = 0; i < LED_COUNT; i++)
         send_request(OP_ANIMATE, IDX_BITS'(i), 1'b0,
                      (i == 3) ? 16'd0 : TICK_BITS'((i % 2) + 1),
                      (i == 5) ? 16'd0 : 16'd2);
      repeat (4) send_request(OP_TICK, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF);
      // Force levels and toggles; they stop blinking.
      send_request(OP_SET, 3'd1, 1'b0, 16'h0000, 16'h0000);
      send_request(OP_SET, 3'd2, 1'b1, 16'hFFFF, 16'hFFFF);
      send_request(OP_TOGGLE, 3'd4, 1'b0, 16'h0000, 16'h0000);
      send_request(OP_TOGGLE, 3'd0, 1'b1, 16'h0000, 16'h0000);
      // Out-of-range LED index: must be dropped.
      send_request(OP_ANIMATE, 3'd7, 1'b1, 16'd1, 16'd1);
      send_request(OP_SET, 3'd7, 1'b1, 16'd0, 16'd0);
      send_request(OP_TOGGLE, 3'd7, 1'b0, 16'd0, 16'd0);
      // Extreme and alternating durations.
      send_request(OP_ANIMATE, 3'd6, 1'b0, 16'hFFFF, 16'hFFFF);
      send_request(OP_ANIMATE, 3'd5, 1'b1, 16'hAAAA, 16'h5555);
      repeat (3) send_request(OP_TICK, 3'd0, 1'b0, 16'h0000, 16'h0000);

      // Random: ticks dominate so the counters run; ignored requests don't count.
      sent = 0;
      while (sent < REAL_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 50)      op = OP_TICK;
         else if (roll < 72) op = OP_ANIMATE;
         else if (roll < 86) op = OP_SET;
         else                op = OP_TOGGLE;
         idx = ($urandom_range(0, 99) < 5) ? 3'd7 : IDX_BITS'($urandom_range(0, 6));
         send_request(op, idx, 1'($urandom), pick_duration(), pick_duration());
         if (op == OP_TICK || idx < LED_COUNT) sent++;
      end
      req_valid <= 1'b0;

      // Drain pending port bytes, then let the pipeline settle.
      waited = 0;
      while (tracker.expected_patterns.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.failures += tracker.expected_patterns.size();

      if (tracker.failures == 0)
         $display("multi_led_blink_controller regression: pass");
      else
         $display("multi_led_blink_controller regression: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #20000000;
      $display("multi_led_blink_controller regression: fail");
      $finish;
   end

endmodule
